// File: design/fcdma_pkg.sv
package fcdma_pkg;

   localparam int NUM_CHANNELS = 4;

   localparam int CHAN_W  = 2;
   localparam int ADDR_W  = 32;
   localparam int COUNT_W = 22;
   localparam int LEFT_W  = 23;

   localparam int REQ_DATA_W = 96;
   localparam int REQ_USER_W = 5;
   localparam int RSP_DATA_W = 64;
   localparam int RSP_USER_W = 4;

   localparam int RSP_DEPTH   = 3;
   localparam int RSP_PTR_W   = $clog2(RSP_DEPTH);
   localparam int RSP_COUNT_W = $clog2(RSP_DEPTH + 1);

   localparam logic [LEFT_W-1:0] MAX_WIDE_COUNT = 23'h200000;
   localparam logic [LEFT_W-1:0] MAX_HALF_COUNT = 23'h400000;

   typedef enum logic [2:0] {
      REQ_SETUP   = 3'd0,
      REQ_HBLANK  = 3'd1,
      REQ_VBLANK  = 3'd2,
      REQ_SPECIAL = 3'd3,
      REQ_START   = 3'd4,
      REQ_CANCEL  = 3'd5,
      REQ_ADVANCE = 3'd6
   } req_kind_type;

   localparam logic [1:0] MODE_INC   = 2'd0;
   localparam logic [1:0] MODE_DEC   = 2'd1;
   localparam logic [1:0] MODE_FIXED = 2'd2;

   localparam logic [1:0] TIMING_IMMEDIATE = 2'd0;
   localparam logic [1:0] TIMING_VBLANK    = 2'd1;
   localparam logic [1:0] TIMING_HBLANK    = 2'd2;
   localparam logic [1:0] TIMING_SPECIAL   = 2'd3;

   typedef struct packed {
      logic       irq_enable;
      logic [1:0] start_timing;
      logic       repeat_mode;
      logic       wide_units;
      logic [1:0] dest_mode;
      logic [1:0] source_mode;
   } settings_type;

   typedef struct packed {
      logic [ADDR_W-1:0] source;
      logic [ADDR_W-1:0] dest;
      logic [LEFT_W-1:0] count;
   } run_type;

   typedef struct packed {
      settings_type settings;
      run_type      saved;
   } cfg_entry_type;

   typedef struct packed {
      logic              irq_raise;
      logic [CHAN_W-1:0] source_channel;
      logic              unit_wide;
      logic              last;
      logic [ADDR_W-1:0] write_address;
      logic [ADDR_W-1:0] read_address;
   } rsp_type;

endpackage

// File: design/four_channel_dma_address_sequencer.sv
// An advance transaction is registered in the write-back stage and then in the result queue.
// Throughput: one transaction per cycle while req_tready is high; the channel memories are
// read for each new transaction as the previous writes back, with same-channel forwarding.
// Reset is synchronous and active high; it clears the channel enable and active flags, the
// pipeline and the result queue. The channel memories are not cleared.
module four_channel_dma_address_sequencer (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // source_start, dest_start, unit_count, source_mode, dest_mode, wide_units,
   // repeat_mode, start_timing, irq_enable, one zero pad bit
   input  logic [fcdma_pkg::REQ_DATA_W-1:0]   req_tdata,
   // req_type, channel
   input  logic [fcdma_pkg::REQ_USER_W-1:0]   req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // read_address, write_address
   output logic [fcdma_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // unit_wide, source_channel, irq_raise
   output logic [fcdma_pkg::RSP_USER_W-1:0]   rsp_tuser,
   output logic                               rsp_tlast
);
   import fcdma_pkg::*;

   typedef enum logic {
      KIND_SETUP,
      KIND_ADVANCE
   } stage_kind_type;

   logic [2:0]          req_kind;
   logic [CHAN_W-1:0]   req_chan;
   logic                req_fire;
   logic                chan_ok;
   settings_type        req_settings;
   run_type             req_run;
   logic [COUNT_W-1:0]  req_count;

   logic [NUM_CHANNELS-1:0] enabled_ff;
   logic [NUM_CHANNELS-1:0] enabled_in;
   logic [NUM_CHANNELS-1:0] active_ff;
   logic [NUM_CHANNELS-1:0] active_in;
   logic [NUM_CHANNELS-1:0] enabled_mid;
   logic [NUM_CHANNELS-1:0] active_mid;
   logic [1:0]              timing_ff [NUM_CHANNELS];

   logic                sel_found;
   logic [CHAN_W-1:0]   sel_chan;
   logic [CHAN_W-1:0]   rd_chan;

   logic                s1_valid_ff;
   logic                s1_valid_in;
   stage_kind_type      s1_kind_ff;
   logic [CHAN_W-1:0]   s1_chan_ff;
   settings_type        s1_settings_ff;
   run_type             s1_run_ff;

   cfg_entry_type       cfg_mem [NUM_CHANNELS];
   run_type             work_mem [NUM_CHANNELS];
   cfg_entry_type       cfg_rd_ff;
   run_type             work_rd_ff;

   logic                fw_valid_ff;
   logic [CHAN_W-1:0]   fw_chan_ff;
   run_type             fw_data_ff;

   logic                b_adv;
   logic                fw_hit;
   run_type             cur;
   settings_type        st;
   logic [ADDR_W-1:0]   addr_mask;
   logic [LEFT_W-1:0]   left_dec;
   logic                run_last;
   logic                end_clear;
   logic                work_we;
   run_type             work_wdata;
   logic                cfg_we;

   rsp_type                rsp_push_data;
   rsp_type                rsp_head;
   logic [RSP_COUNT_W-1:0] rsp_count;
   logic [RSP_COUNT_W:0]   rsp_reserved;

   function automatic logic [ADDR_W-1:0] step_addr(input logic [ADDR_W-1:0] addr,
                                                   input logic [1:0] mode,
                                                   input logic wide);
      logic [ADDR_W-1:0] unit;
      unit = wide ? ADDR_W'(4) : ADDR_W'(2);
      case (mode)
         MODE_DEC:   return addr - unit;
         MODE_FIXED: return addr;
         default:    return addr + unit;
      endcase
   endfunction

   assign req_kind  = req_tuser[2:0];
   assign req_chan  = req_tuser[4:3];
   assign req_count = req_tdata[85:64];
   assign req_fire  = req_tvalid && req_tready;
   assign chan_ok   = (int'(req_chan) < NUM_CHANNELS);

   assign req_settings.source_mode  = req_tdata[87:86];
   assign req_settings.dest_mode    = req_tdata[89:88];
   assign req_settings.wide_units   = req_tdata[90];
   assign req_settings.repeat_mode  = req_tdata[91];
   assign req_settings.start_timing = req_tdata[93:92];
   assign req_settings.irq_enable   = req_tdata[94];

   assign req_run.source = req_tdata[31:0];
   assign req_run.dest   = req_tdata[63:32];
   assign req_run.count  = (req_count != '0) ? {1'b0, req_count} :
                           (req_tdata[90] ? MAX_WIDE_COUNT : MAX_HALF_COUNT);

   // Write-back stage: the item accepted last cycle, with the memory data it read.
   assign b_adv     = s1_valid_ff && (s1_kind_ff == KIND_ADVANCE);
   assign fw_hit    = fw_valid_ff && (fw_chan_ff == s1_chan_ff);
   assign cur       = fw_hit ? fw_data_ff : work_rd_ff;
   assign st        = cfg_rd_ff.settings;
   assign addr_mask = {{(ADDR_W - 2){1'b1}}, ~st.wide_units, 1'b0};
   assign left_dec  = cur.count - LEFT_W'(cur.count != '0);
   assign run_last  = (left_dec == '0);
   assign end_clear = b_adv && run_last;

   always_comb begin
      work_we    = s1_valid_ff;
      cfg_we     = s1_valid_ff && (s1_kind_ff == KIND_SETUP);
      work_wdata = s1_run_ff;
      if (b_adv) begin
         if (run_last && st.repeat_mode) begin
            work_wdata = cfg_rd_ff.saved;
         end else begin
            work_wdata.source = step_addr(cur.source, st.source_mode, st.wide_units);
            work_wdata.dest   = step_addr(cur.dest, st.dest_mode, st.wide_units);
            work_wdata.count  = left_dec;
         end
      end
   end

   assign rsp_push_data.read_address   = cur.source & addr_mask;
   assign rsp_push_data.write_address  = cur.dest & addr_mask;
   assign rsp_push_data.unit_wide      = st.wide_units;
   assign rsp_push_data.source_channel = s1_chan_ff;
   assign rsp_push_data.last           = run_last;
   assign rsp_push_data.irq_raise      = run_last && st.irq_enable;

   // The end of a run in the write-back stage comes before the newly accepted transaction.
   always_comb begin
      enabled_mid = enabled_ff;
      active_mid  = active_ff;
      if (end_clear) begin
         active_mid[s1_chan_ff] = 1'b0;
         if (!st.repeat_mode) begin
            enabled_mid[s1_chan_ff] = 1'b0;
         end
      end
   end

   always_comb begin
      sel_found = 1'b0;
      sel_chan  = '0;
      for (int c = NUM_CHANNELS - 1; c >= 0; c--) begin
         if (active_mid[c]) begin
            sel_found = 1'b1;
            sel_chan  = CHAN_W'(c);
         end
      end
   end

   assign rd_chan = (req_kind == REQ_ADVANCE) ? sel_chan : req_chan;

   always_comb begin
      enabled_in = enabled_mid;
      active_in  = active_mid;
      if (req_fire) begin
         case (req_kind)
            REQ_SETUP: begin
               if (chan_ok) begin
                  enabled_in[req_chan] = 1'b1;
                  active_in[req_chan]  = 1'b0;
               end
            end
            REQ_HBLANK: begin
               for (int c = 0; c < NUM_CHANNELS; c++) begin
                  if (enabled_mid[c] && timing_ff[c] == TIMING_HBLANK) begin
                     active_in[c] = 1'b1;
                  end
               end
            end
            REQ_VBLANK: begin
               for (int c = 0; c < NUM_CHANNELS; c++) begin
                  if (enabled_mid[c] && timing_ff[c] == TIMING_VBLANK) begin
                     active_in[c] = 1'b1;
                  end
               end
            end
            REQ_SPECIAL: begin
               for (int c = 0; c < NUM_CHANNELS; c++) begin
                  if (enabled_mid[c] && timing_ff[c] == TIMING_SPECIAL) begin
                     active_in[c] = 1'b1;
                  end
               end
            end
            REQ_START: begin
               if (chan_ok && enabled_mid[req_chan]) begin
                  active_in[req_chan] = 1'b1;
               end
            end
            REQ_CANCEL: begin
               if (chan_ok) begin
                  enabled_in[req_chan] = 1'b0;
                  active_in[req_chan]  = 1'b0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign s1_valid_in = req_fire &&
                        (((req_kind == REQ_SETUP) && chan_ok) ||
                         ((req_kind == REQ_ADVANCE) && sel_found));

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff  <= '0;
         active_ff   <= '0;
         s1_valid_ff <= 1'b0;
         fw_valid_ff <= 1'b0;
      end else begin
         enabled_ff  <= enabled_in;
         active_ff   <= active_in;
         s1_valid_ff <= s1_valid_in;
         fw_valid_ff <= work_we;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_kind_ff     <= (req_kind == REQ_ADVANCE) ? KIND_ADVANCE : KIND_SETUP;
         s1_chan_ff     <= rd_chan;
         s1_settings_ff <= req_settings;
         s1_run_ff      <= req_run;
         if (req_kind == REQ_SETUP && chan_ok) begin
            timing_ff[req_chan] <= req_settings.start_timing;
         end
      end
      fw_chan_ff <= s1_chan_ff;
      fw_data_ff <= work_wdata;
   end

   always_ff @(posedge clock) begin
      cfg_rd_ff  <= cfg_mem[rd_chan];
      work_rd_ff <= work_mem[rd_chan];
      if (cfg_we) begin
         cfg_mem[s1_chan_ff] <= {s1_settings_ff, s1_run_ff};
      end
      if (work_we) begin
         work_mem[s1_chan_ff] <= work_wdata;
      end
   end

   // Room is held for the transaction in the write-back stage.
   assign rsp_reserved = {1'b0, rsp_count} + (RSP_COUNT_W + 1)'(b_adv);
   assign req_tready   = (rsp_reserved <= (RSP_COUNT_W + 1)'(RSP_DEPTH - 1));

   fcdma_rsp_fifo u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (b_adv),
      .push_data  (rsp_push_data),
      .pop_ready  (rsp_tready),
      .pop_valid  (rsp_tvalid),
      .pop_data   (rsp_head),
      .count      (rsp_count)
   );

   assign rsp_tdata = {rsp_head.write_address, rsp_head.read_address};
   assign rsp_tuser = {rsp_head.irq_raise, rsp_head.source_channel, rsp_head.unit_wide};
   assign rsp_tlast = rsp_head.last;

   a_rsp_no_overflow: assert property (@(posedge clock) disable iff (reset)
      b_adv |-> (rsp_count != RSP_COUNT_W'(RSP_DEPTH) || (rsp_tvalid && rsp_tready)))
      else $error("Result queue overflow.");

   a_active_needs_enabled: assert property (@(posedge clock) disable iff (reset)
      (active_ff & ~enabled_ff) == '0)
      else $error("A channel is active while disabled.");

   a_advance_from_active: assert property (@(posedge clock) disable iff (reset)
      b_adv |-> active_ff[s1_chan_ff])
      else $error("An advance transaction is served by an inactive channel.");

endmodule

// File: design/fcdma_rsp_fifo.sv
module fcdma_rsp_fifo (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                push_valid,
   input  fcdma_pkg::rsp_type                  push_data,
   input  logic                                pop_ready,
   output logic                                pop_valid,
   output fcdma_pkg::rsp_type                  pop_data,
   output logic [fcdma_pkg::RSP_COUNT_W-1:0]   count
);
   import fcdma_pkg::*;

   rsp_type                entry_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0]   wr_ptr_ff;
   logic [RSP_PTR_W-1:0]   wr_ptr_in;
   logic [RSP_PTR_W-1:0]   rd_ptr_ff;
   logic [RSP_PTR_W-1:0]   rd_ptr_in;
   logic [RSP_COUNT_W-1:0] count_ff;
   logic [RSP_COUNT_W-1:0] count_in;
   logic                   pop_fire;

   function automatic logic [RSP_PTR_W-1:0] next_ptr(input logic [RSP_PTR_W-1:0] ptr);
      if (ptr == RSP_PTR_W'(RSP_DEPTH - 1)) begin
         return '0;
      end
      return ptr + RSP_PTR_W'(1);
   endfunction

   assign pop_valid = (count_ff != '0);
   assign pop_data  = entry_ff[rd_ptr_ff];
   assign pop_fire  = pop_valid && pop_ready;
   assign count     = count_ff;

   always_comb begin
      wr_ptr_in = push_valid ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop_fire ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push_valid && !pop_fire) begin
         count_in = count_ff + RSP_COUNT_W'(1);
      end else if (!push_valid && pop_fire) begin
         count_in = count_ff - RSP_COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: sim/four_channel_dma_address_sequencer_test.sv
module four_channel_dma_address_sequencer_test;
   timeunit 1ns;
   timeprecision 1ps;

   import fcdma_pkg::*;

   localparam logic [2:0] REQ_UNUSED = 3'd7;
   localparam logic [1:0] MODE_INC_RELOAD = 2'd3;
   localparam int SETTINGS_W = $bits(settings_type);
   localparam int RANDOM_REQUESTS = 1750;
   localparam int HOLD_CYCLES = 100;

   typedef struct packed {
      logic [2:0]         kind;
      logic [CHAN_W-1:0]  channel;
      logic [ADDR_W-1:0]  source_start;
      logic [ADDR_W-1:0]  dest_start;
      logic [COUNT_W-1:0] unit_count;
      settings_type       settings;
   } dma_request_type;

   class dma_transfer_scoreboard;
      logic              enabled [NUM_CHANNELS];
      logic              active [NUM_CHANNELS];
      settings_type      chan_cfg [NUM_CHANNELS];
      logic [ADDR_W-1:0] start_source [NUM_CHANNELS];
      logic [ADDR_W-1:0] start_dest [NUM_CHANNELS];
      logic [LEFT_W-1:0] run_length [NUM_CHANNELS];
      logic [ADDR_W-1:0] next_source [NUM_CHANNELS];
      logic [ADDR_W-1:0] next_dest [NUM_CHANNELS];
      logic [LEFT_W-1:0] remaining [NUM_CHANNELS];
      rsp_type           transfer_q [$];
      int                errors;

      function new();
         for (int c = 0; c < NUM_CHANNELS; c++) begin
            enabled[c] = 1'b0;
            active[c] = 1'b0;
            chan_cfg[c] = '0;
            start_source[c] = '0;
            start_dest[c] = '0;
            run_length[c] = '0;
            next_source[c] = '0;
            next_dest[c] = '0;
            remaining[c] = '0;
         end
         errors = 0;
      endfunction

      function void arm_channel(int c);
         if (!enabled[c] || active[c]) return;
         active[c] = 1'b1;
         next_source[c] = start_source[c];
         next_dest[c] = start_dest[c];
         remaining[c] = run_length[c];
      endfunction

      function void arm_on_event(logic [1:0] timing);
         for (int c = 0; c < NUM_CHANNELS; c++)
            if (enabled[c] && chan_cfg[c].start_timing == timing) arm_channel(c);
      endfunction

      function logic [ADDR_W-1:0] stepped(logic [ADDR_W-1:0] addr, logic [1:0] mode,
                                           logic [ADDR_W-1:0] unit);
         if (mode == MODE_DEC) return addr - unit;
         if (mode == MODE_FIXED) return addr;
         return addr + unit;
      endfunction

      function void note_request(dma_request_type r);
         logic [LEFT_W-1:0] count;
         logic [ADDR_W-1:0] unit;
         logic [ADDR_W-1:0] mask;
         rsp_type           exp;
         int                c;
         case (r.kind)
            REQ_SETUP: begin
               c = int'(r.channel);
               count = {1'b0, r.unit_count};
               if (r.unit_count == '0)
                  count = r.settings.wide_units ? MAX_WIDE_COUNT : MAX_HALF_COUNT;
               start_source[c] = r.source_start;
               start_dest[c] = r.dest_start;
               run_length[c] = count;
               chan_cfg[c] = r.settings;
               next_source[c] = r.source_start;
               next_dest[c] = r.dest_start;
               remaining[c] = count;
               enabled[c] = 1'b1;
               active[c] = 1'b0;
            end
            REQ_HBLANK:  arm_on_event(TIMING_HBLANK);
            REQ_VBLANK:  arm_on_event(TIMING_VBLANK);
            REQ_SPECIAL: arm_on_event(TIMING_SPECIAL);
            REQ_START:   arm_channel(int'(r.channel));
            REQ_CANCEL: begin
               enabled[r.channel] = 1'b0;
               active[r.channel] = 1'b0;
            end
            REQ_ADVANCE: begin
               c = 0;
               while (c < NUM_CHANNELS && !active[c]) c++;
               if (c < NUM_CHANNELS) begin
                  unit = chan_cfg[c].wide_units ? 32'd4 : 32'd2;
                  mask = chan_cfg[c].wide_units ? ~32'h3 : ~32'h1;
                  exp.read_address = next_source[c] & mask;
                  exp.write_address = next_dest[c] & mask;
                  exp.unit_wide = chan_cfg[c].wide_units;
                  exp.source_channel = c[CHAN_W-1:0];
                  next_source[c] = stepped(next_source[c], chan_cfg[c].source_mode, unit);
                  next_dest[c] = stepped(next_dest[c], chan_cfg[c].dest_mode, unit);
                  if (remaining[c] != '0) remaining[c]--;
                  exp.last = (remaining[c] == '0);
                  exp.irq_raise = exp.last && chan_cfg[c].irq_enable;
                  if (exp.last) begin
                     active[c] = 1'b0;
                     if (chan_cfg[c].repeat_mode) begin
                        next_source[c] = start_source[c];
                        next_dest[c] = start_dest[c];
                        remaining[c] = run_length[c];
                     end else begin
                        enabled[c] = 1'b0;
                     end
                  end
                  transfer_q.push_back(exp);
               end
            end
            default: ;
         endcase
      endfunction

      function void check_result(rsp_type got);
         rsp_type exp;
         if (transfer_q.size() == 0) begin
            $error("unexpected transfer: read %h write %h channel %0d",
                   got.read_address, got.write_address, got.source_channel);
            errors++;
            return;
         end
         exp = transfer_q.pop_front();
         if (got.read_address !== exp.read_address) begin
            $error("read_address: expected %h, actual %h", exp.read_address, got.read_address);
            errors++;
         end
         if (got.write_address !== exp.write_address) begin
            $error("write_address: expected %h, actual %h", exp.write_address,
                   got.write_address);
            errors++;
         end
         if (got.unit_wide !== exp.unit_wide) begin
            $error("unit_wide: expected %b, actual %b", exp.unit_wide, got.unit_wide);
            errors++;
         end
         if (got.source_channel !== exp.source_channel) begin
            $error("source_channel: expected %0d, actual %0d", exp.source_channel,
                   got.source_channel);
            errors++;
         end
         if (got.last !== exp.last) begin
            $error("last: expected %b, actual %b", exp.last, got.last);
            errors++;
         end
         if (got.irq_raise !== exp.irq_raise) begin
            $error("irq_raise: expected %b, actual %b", exp.irq_raise, got.irq_raise);
            errors++;
         end
      endfunction

      function int outstanding();
         return transfer_q.size();
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [REQ_USER_W-1:0] req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic                  rsp_tlast;

   bit no_gaps = 1'b0;
   bit hold_request = 1'b0;
   int hold_left = 0;

   dma_transfer_scoreboard transfers = new();

   four_channel_dma_address_sequencer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   initial begin
      #2_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   // The receiver stalls at random, or for a long counted stretch on request.
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (hold_request) begin
         hold_request <= 1'b0;
         hold_left <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= no_gaps || ($urandom_range(99) >= 18);
      end
   end

   always @(posedge clock) begin
      rsp_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.read_address = rsp_tdata[31:0];
         got.write_address = rsp_tdata[63:32];
         got.unit_wide = rsp_tuser[0];
         got.source_channel = rsp_tuser[2:1];
         got.irq_raise = rsp_tuser[3];
         got.last = rsp_tlast;
         transfers.check_result(got);
      end
   end

   task automatic send_request(input dma_request_type r);
      @(negedge clock);
      while (!no_gaps && $urandom_range(99) < 18) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {1'b0, r.settings, r.unit_count, r.dest_start, r.source_start};
      req_tuser <= {r.channel, r.kind};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      transfers.note_request(r);
   endtask

   task automatic send_setup(input logic [1:0] ch, input logic [31:0] src,
                             input logic [31:0] dst, input logic [21:0] count,
                             input logic [1:0] smode, input logic [1:0] dmode,
                             input logic wide, input logic rep, input logic [1:0] timing,
                             input logic irq);
      dma_request_type r;
      r.kind = REQ_SETUP;
      r.channel = ch;
      r.source_start = src;
      r.dest_start = dst;
      r.unit_count = count;
      r.settings.source_mode = smode;
      r.settings.dest_mode = dmode;
      r.settings.wide_units = wide;
      r.settings.repeat_mode = rep;
      r.settings.start_timing = timing;
      r.settings.irq_enable = irq;
      send_request(r);
   endtask

   task automatic send_control(input logic [2:0] kind, input logic [1:0] ch);
      dma_request_type r;
      r.kind = kind;
      r.channel = ch;
      r.source_start = $urandom;
      r.dest_start = $urandom;
      r.unit_count = COUNT_W'($urandom);
      r.settings = settings_type'(SETTINGS_W'($urandom));
      send_request(r);
   endtask

   task automatic drain_transfers();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (transfers.outstanding() != 0) @(posedge clock);
   endtask

   task automatic send_random_setup();
      logic [21:0] count;
      int          pick;
      pick = $urandom_range(99);
      if (pick < 4) count = COUNT_W'($urandom);
      else if (pick < 7) count = '0;
      else count = COUNT_W'($urandom_range(1, 12));
      send_setup(CHAN_W'($urandom), $urandom, $urandom, count, 2'($urandom), 2'($urandom),
                 1'($urandom), 1'($urandom), 2'($urandom), 1'($urandom));
   endtask

   initial begin
      int sent;
      int pick;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_setup(2'd0, 32'hFFFF_FFFF, 32'h0000_0000, 22'd1, MODE_INC, MODE_DEC, 1'b1, 1'b0,
                 TIMING_IMMEDIATE, 1'b1);
      send_control(REQ_ADVANCE, 2'd0);
      send_control(REQ_VBLANK, 2'd0);
      send_control(REQ_START, 2'd0);
      send_control(REQ_ADVANCE, 2'd0);
      send_control(REQ_ADVANCE, 2'd0);
      send_setup(2'd1, 32'h0000_0000, 32'hFFFF_FFFF, 22'd2, MODE_DEC, MODE_FIXED, 1'b0, 1'b1,
                 TIMING_HBLANK, 1'b1);
      send_control(REQ_HBLANK, 2'd1);
      send_control(REQ_ADVANCE, 2'd1);
      send_control(REQ_HBLANK, 2'd1);
      send_control(REQ_ADVANCE, 2'd1);
      send_control(REQ_HBLANK, 2'd1);
      send_control(REQ_ADVANCE, 2'd1);
      send_setup(2'd2, 32'h1234_5677, 32'h8765_4323, 22'd0, MODE_INC_RELOAD, MODE_INC_RELOAD,
                 1'b1, 1'b0, TIMING_VBLANK, 1'b0);
      send_control(REQ_VBLANK, 2'd2);
      send_control(REQ_ADVANCE, 2'd2);
      send_setup(2'd2, 32'hAAAA_5555, 32'h5555_AAAA, 22'h3F_FFFF, MODE_INC, MODE_INC, 1'b0,
                 1'b1, TIMING_SPECIAL, 1'b0);
      send_control(REQ_ADVANCE, 2'd2);
      send_control(REQ_SPECIAL, 2'd2);
      send_control(REQ_START, 2'd2);
      send_control(REQ_ADVANCE, 2'd2);
      send_control(REQ_UNUSED, 2'd3);
      send_control(REQ_CANCEL, 2'd2);
      send_control(REQ_CANCEL, 2'd1);
      send_control(REQ_ADVANCE, 2'd3);
      drain_transfers();

      sent = 0;
      while (sent < RANDOM_REQUESTS) begin
         if (sent == 400) hold_request = 1'b1;
         if (sent == 900) drain_transfers();
         no_gaps = (sent >= 1100 && sent < 1400);
         pick = $urandom_range(99);
         if (pick < 12) send_random_setup();
         else if (pick < 17) send_control(REQ_HBLANK, CHAN_W'($urandom));
         else if (pick < 21) send_control(REQ_VBLANK, CHAN_W'($urandom));
         else if (pick < 25) send_control(REQ_SPECIAL, CHAN_W'($urandom));
         else if (pick < 37) send_control(REQ_START, CHAN_W'($urandom));
         else if (pick < 41) send_control(REQ_CANCEL, CHAN_W'($urandom));
         else if (pick < 98) send_control(REQ_ADVANCE, CHAN_W'($urandom));
         else send_control(REQ_UNUSED, CHAN_W'($urandom));
         if (pick < 98) sent++;
      end
      no_gaps = 1'b0;

      drain_transfers();
      repeat (20) @(posedge clock);
      if (transfers.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
